FILE: rtl/per_core_page_free_list_allocator_macros.svh
// Assertion macros shared by the page allocator RTL.
`ifndef PER_CORE_PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH
`define PER_CORE_PAGE_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFLA_ASSERT_SAME(LBL, CLK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANT) |-> (CON)) \
        else $error(MSG);

// Next-cycle implication, disabled while reset is asserted.
`define PFLA_ASSERT_NEXT(LBL, CLK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!(RSTN)) (ANT) |=> (CON)) \
        else $error(MSG);

`endif

FILE: rtl/pfla_pkg.sv
// Shared types and constants of the per-core page allocator.
`timescale 1ns / 1ps
package pfla_pkg;

    // operation codes
    localparam logic OP_FREE  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OOM      = 2'd1;
    localparam logic [1:0] ST_BAD_ADDR = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP   = 1'd1;

    localparam logic [31:0] KERNEL_END_RST = 32'h8000_0000;
    localparam logic [31:0] PHYS_TOP_RST   = 32'h8800_0000;

    typedef struct packed {
        logic        op;
        logic [2:0]  core_id;
        logic [31:0] phys_addr;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] page_addr;
        logic [2:0]  source_core;
    } t_rsp;

    // one-hot step commands from the controller to the datapath
    typedef struct packed {
        logic cap;
        logic chk;
        logic calc;
        logic fin;
    } t_cmd;

endpackage

FILE: rtl/pfla_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pfla_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/pfla_ctrl.sv
// Sequencing state machine of the page allocator.
`timescale 1ns / 1ps
module pfla_ctrl
    import pfla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_is_alloc,
    output logic o_busy,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CHK  = 2'd1;
    localparam logic [1:0] S_CALC = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = S_CALC;
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_is_alloc ? S_IDLE : S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/pfla_dp.sv
// Datapath: config registers, list heads, link memory, checks and result register.
`timescale 1ns / 1ps
module pfla_dp
    import pfla_pkg::*;
#(
    parameter int CORES      = 8,
    parameter int PAGE_SHIFT = 12,
    parameter int PAGES      = 32768
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    input  t_req                 i_req,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata,
    output logic                 o_is_alloc,
    output logic                 o_valid,
    output t_rsp                 o_rsp
);

    localparam int IW = $clog2(PAGES);
    localparam int CW = (CORES > 1) ? $clog2(CORES) : 1;
    localparam int LW = IW + 1;
    localparam int XW = 32 + IW;
    localparam logic [32:0] PG_MASK = 33'((64'd1 << PAGE_SHIFT) - 64'd1);

    // control state
    logic [31:0]   r_kend;
    logic [31:0]   r_ptop;
    logic [IW-1:0] r_head [CORES];
    logic          r_ne   [CORES];
    logic          r_valid;

    // payload registers
    t_req          r_req;
    logic [32:0]   r_base;
    logic          r_bad;
    logic [CW-1:0] r_src;
    logic          r_found;
    logic [IW-1:0] r_pop_idx;
    logic [IW-1:0] r_idx;
    logic          r_good;
    t_rsp          r_rsp;

    logic          w_own_ok;
    logic          w_any;
    logic [CW-1:0] w_steal;
    logic [CW-1:0] w_pick;
    logic [CW-1:0] w_own;
    logic          w_found;
    logic [32:0]   w_base;
    logic          w_bad;
    logic [32:0]   w_diff;
    logic [XW-1:0] w_idx_full;
    logic          w_in_range;
    logic [XW:0]   w_off_ext;
    logic [32:0]   w_page_sum;
    logic [LW-1:0] w_link;
    logic          w_ram_we;
    logic [LW-1:0] w_ram_wdata;

    assign w_own    = CW'(r_req.core_id);
    assign w_own_ok = (32'(r_req.core_id) < 32'(CORES)) && r_ne[w_own];

    // lowest non-empty list wins a steal
    always_comb begin
        w_any   = 1'b0;
        w_steal = '0;
        for (int c = CORES - 1; c >= 0; c--) begin
            if (r_ne[c]) begin
                w_any   = 1'b1;
                w_steal = CW'(c);
            end
        end
    end

    assign w_pick  = w_own_ok ? w_own : w_steal;
    assign w_found = w_own_ok || w_any;

    // base is kernel end rounded up to a page
    assign w_base = ({1'b0, r_kend} + PG_MASK) & ~PG_MASK;
    assign w_bad  = (32'(r_req.core_id) >= 32'(CORES))
                 || (r_req.phys_addr[PAGE_SHIFT-1:0] != '0)
                 || (r_req.phys_addr < r_kend)
                 || (r_req.phys_addr >= r_ptop);

    assign w_diff     = {1'b0, r_req.phys_addr} - r_base;
    assign w_idx_full = {{IW{1'b0}}, w_diff[31:0]} >> PAGE_SHIFT;
    assign w_in_range = (w_idx_full < XW'(PAGES));

    assign w_off_ext  = (XW + 1)'(r_pop_idx) << PAGE_SHIFT;
    assign w_page_sum = r_base + w_off_ext[32:0];

    assign w_ram_we    = i_cmd.fin && r_good;
    assign w_ram_wdata = {r_ne[w_own], r_head[w_own]};

    pfla_ram #(
        .WIDTH (LW),
        .DEPTH (PAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_idx),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_head[w_pick]),
        .o_rdata (w_link)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kend  <= KERNEL_END_RST;
            r_ptop  <= PHYS_TOP_RST;
            r_valid <= 1'b0;
            for (int c = 0; c < CORES; c++) begin
                r_head[c] <= '0;
                r_ne[c]   <= 1'b0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_KERNEL_END: r_kend <= i_cfg_wdata;
                    CFG_PHYS_TOP:   r_ptop <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_valid <= (i_cmd.calc && (r_req.op == OP_ALLOC)) || i_cmd.fin;
            // pop: link of old head becomes the new head
            if (i_cmd.calc && (r_req.op == OP_ALLOC) && r_found) begin
                r_head[r_src] <= w_link[IW] ? w_link[IW-1:0] : '0;
                r_ne[r_src]   <= w_link[IW];
            end
            // push
            if (w_ram_we) begin
                r_head[w_own] <= r_idx;
                r_ne[w_own]   <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req <= i_req;
        end
        if (i_cmd.chk) begin
            r_base    <= w_base;
            r_bad     <= w_bad;
            r_src     <= w_pick;
            r_found   <= w_found;
            r_pop_idx <= r_head[w_pick];
        end
        if (i_cmd.calc) begin
            r_idx  <= w_idx_full[IW-1:0];
            r_good <= !r_bad && !w_diff[32] && w_in_range;
            if (r_req.op == OP_ALLOC) begin
                if (r_found) begin
                    r_rsp.status      <= ST_OK;
                    r_rsp.page_addr   <= w_page_sum[31:0];
                    r_rsp.source_core <= 3'(r_src);
                end else begin
                    r_rsp.status      <= ST_OOM;
                    r_rsp.page_addr   <= '0;
                    r_rsp.source_core <= '0;
                end
            end
        end
        if (i_cmd.fin) begin
            r_rsp.status      <= r_good ? ST_OK : ST_BAD_ADDR;
            r_rsp.page_addr   <= '0;
            r_rsp.source_core <= '0;
        end
    end

    assign o_is_alloc = (r_req.op == OP_ALLOC);
    assign o_valid    = r_valid;
    assign o_rsp      = r_rsp;

endmodule

FILE: rtl/per_core_page_free_list_allocator.sv
// Top level of the per-core page free-list allocator with stealing.
//
//  Channel   Ports                                    Transaction when
//  --------  ---------------------------------------  -------------------------
//  request   start, busy, i_req                       start && !busy at clk edge
//  result    o_valid, o_rsp                           o_valid high (one cycle)
//  config    i_cfg_we, i_cfg_idx, i_cfg_wdata         i_cfg_we high at clk edge
//
//  Each transaction runs the controller's step sequence: check, then compute,
//  then (free only) the link memory write. The result strobe is registered
//  after the last step; the next transaction may be accepted while it shows.
//  Reset is synchronous, active low; it empties every list and restores the
//  address registers. The link memory is not cleared (no clearing pass).
//  The receiver cannot stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps
`include "per_core_page_free_list_allocator_macros.svh"
module per_core_page_free_list_allocator
    import pfla_pkg::*;
#(
    parameter int CORES      = 8,
    parameter int PAGE_SHIFT = 12,
    parameter int PAGES      = 32768
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_req                 i_req,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]          i_cfg_wdata,
    output logic                 o_valid,
    output t_rsp                 o_rsp
);

    t_cmd w_cmd;        // step strobes, one per controller state
    logic w_is_alloc;   // captured transaction is an allocate

    pfla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_is_alloc (w_is_alloc),
        .o_busy     (busy),
        .o_cmd      (w_cmd)
    );

    // Datapath: list heads and non-empty flags in flops, links in a RAM.
    // A pop reads the head's link during the check step; a push writes the
    // old head as the new page's link in the final step.
    pfla_dp #(
        .CORES      (CORES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .PAGES      (PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_is_alloc  (w_is_alloc),
        .o_valid     (o_valid),
        .o_rsp       (o_rsp)
    );

    // accepted transaction keeps the block busy in the next cycle
    `PFLA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "busy not raised after accept")
    // result strobe only once the sequence has returned to idle
    `PFLA_ASSERT_SAME(a_valid_idle, i_clk, i_rst_n, o_valid, !busy, "result while busy")
    // single-cycle strobe per transaction
    `PFLA_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid, "result strobe repeated")
    // results with an error status carry no page
    `PFLA_ASSERT_SAME(a_err_no_page, i_clk, i_rst_n, o_valid && (o_rsp.status != ST_OK), o_rsp.page_addr == 32'd0, "page address on error")

endmodule
